// ===== rtl/core/xtea3_pkg.sv =====
`default_nettype none

package xtea3_pkg;

  // Round sum increment
  localparam logic [31:0] DELTA = 32'h9E3779B9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [7:0] ROUNDS_RESET = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY01  = 3'd0,
    REG_KEY23  = 3'd1,
    REG_KEY45  = 3'd2,
    REG_KEY67  = 3'd3,
    REG_ROUNDS = 3'd4
  } cfg_index_t;

  // Request type
  localparam logic REQ_ENCIPHER = 1'b0;
  localparam logic REQ_DECIPHER = 1'b1;

  // Eight 32-bit key words, word 0 in the low bits
  typedef logic [7:0][31:0] key_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Rotate left by 0..31
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

  // Round mixing function
  function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] s, input logic [1:0] sel,
                                      input key_t k);
    logic [31:0] p;
    logic [31:0] q;
    p = {x[27:0], 4'b0000} + rotl32(k[{1'b1, sel}], x[4:0]);
    q = {5'b00000, x[31:5]} + rotl32(k[{1'b0, sel}], x[31:27]);
    return p ^ (y + s) ^ q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xtea3_block_cipher.sv =====
`default_nettype none

// An accepted request is loaded, then runs R rounds in ST_RUN (R = round_count);
// ST_FINISH then writes the output register and sets out_valid. A new request is
// taken only back in ST_IDLE; the single round unit runs one full round per clock.
// The result sits in an output register, so a stalled result never stalls the rounds.
// Reset (rst, synchronous): key registers clear to zero, round_count to 32,
// controller goes idle and out_valid drops.

module xtea3_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [31:0] in_word0,
  input  wire logic [31:0] in_word1,
  input  wire logic [31:0] in_word2,
  input  wire logic [31:0] in_word3,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_word0,
  output logic [31:0]      out_word1,
  output logic [31:0]      out_word2,
  output logic [31:0]      out_word3
);

  logic [63:0]       key_words_0_1;
  logic [63:0]       key_words_2_3;
  logic [63:0]       key_words_4_5;
  logic [63:0]       key_words_6_7;
  logic [7:0]        round_count;
  xtea3_pkg::key_t   key;
  xtea3_pkg::cmd_t   cmd;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      key_words_0_1 <= 64'd0;
      key_words_2_3 <= 64'd0;
      key_words_4_5 <= 64'd0;
      key_words_6_7 <= 64'd0;
      round_count   <= xtea3_pkg::ROUNDS_RESET;
    end else if (wr_en) begin
      unique case (xtea3_pkg::cfg_index_t'(wr_index))
        xtea3_pkg::REG_KEY01:  key_words_0_1 <= wr_data;
        xtea3_pkg::REG_KEY23:  key_words_2_3 <= wr_data;
        xtea3_pkg::REG_KEY45:  key_words_4_5 <= wr_data;
        xtea3_pkg::REG_KEY67:  key_words_6_7 <= wr_data;
        xtea3_pkg::REG_ROUNDS: round_count   <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign key = {key_words_6_7, key_words_4_5, key_words_2_3, key_words_0_1};

  xtea3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rounds    (round_count),
    .cmd       (cmd)
  );

  xtea3_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .req_type  (req_type),
    .in_word0  (in_word0),
    .in_word1  (in_word1),
    .in_word2  (in_word2),
    .in_word3  (in_word3),
    .key       (key),
    .rounds    (round_count),
    .out_word0 (out_word0),
    .out_word1 (out_word1),
    .out_word2 (out_word2),
    .out_word3 (out_word3)
  );

endmodule

`default_nettype wire

// ===== rtl/core/xtea3_ctrl.sv =====
`default_nettype none

module xtea3_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire logic [7:0]        rounds,
  output xtea3_pkg::cmd_t        cmd
);

  xtea3_pkg::state_t state;
  xtea3_pkg::state_t state_next;
  logic [7:0]        cnt;
  logic              out_take;
  logic              out_free;

  assign in_stall = (state != xtea3_pkg::ST_IDLE);
  assign out_take = out_valid && !out_stall;
  assign out_free = !out_valid || out_take;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xtea3_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      xtea3_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (rounds == 8'd0) ? xtea3_pkg::ST_FINISH : xtea3_pkg::ST_RUN;
        end
      end
      xtea3_pkg::ST_RUN: begin
        cmd.step = 1'b1;
        if (cnt == 8'd1) begin
          state_next = xtea3_pkg::ST_FINISH;
        end
      end
      xtea3_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = xtea3_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = xtea3_pkg::ST_IDLE;
      end
    endcase
  end

  // Count remaining rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 8'd0;
    end else if (cmd.load) begin
      cnt <= rounds;
    end else if (cmd.step) begin
      cnt <= cnt - 8'd1;
    end
  end

  // Hold the result valid until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != xtea3_pkg::ST_IDLE))
    else $error("request accepted but controller stayed idle");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished result not marked valid");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == xtea3_pkg::ST_RUN) |-> (cnt != 8'd0))
    else $error("round counter empty while running");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("more than one datapath command at once");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/xtea3_dp.sv =====
`default_nettype none

module xtea3_dp (
  input  wire logic              clk,
  input  wire xtea3_pkg::cmd_t   cmd,
  input  wire logic              req_type,
  input  wire logic [31:0]       in_word0,
  input  wire logic [31:0]       in_word1,
  input  wire logic [31:0]       in_word2,
  input  wire logic [31:0]       in_word3,
  input  wire xtea3_pkg::key_t   key,
  input  wire logic [7:0]        rounds,
  output logic [31:0]            out_word0,
  output logic [31:0]            out_word1,
  output logic [31:0]            out_word2,
  output logic [31:0]            out_word3
);

  logic        mode;
  logic [31:0] a, b, c, d, sum;
  logic [31:0] sum_init;
  logic [31:0] sum_inc, sum_dec;
  logic [31:0] m0_x, m0_y, m0_s, m1_x, m1_y, m1_s;
  logic [1:0]  m0_sel, m1_sel;
  logic [31:0] m0, m1;

  // Starting sum for decipher
  assign sum_init = xtea3_pkg::DELTA * {24'd0, rounds};

  assign sum_inc = sum + xtea3_pkg::DELTA;
  assign sum_dec = sum - xtea3_pkg::DELTA;

  // Steer the two mixing units by direction
  always_comb begin
    if (mode == xtea3_pkg::REQ_ENCIPHER) begin
      m0_x = b;  m0_y = d;  m0_s = sum;     m0_sel = sum[1:0];
      m1_x = d;  m1_y = b;  m1_s = sum_inc; m1_sel = sum_inc[12:11];
    end else begin
      m0_x = a;  m0_y = c;  m0_s = sum_dec; m0_sel = sum_dec[1:0];
      m1_x = c;  m1_y = a;  m1_s = sum;     m1_sel = sum[12:11];
    end
  end

  assign m0 = xtea3_pkg::mix(m0_x, m0_y, m0_s, m0_sel, key);
  assign m1 = xtea3_pkg::mix(m1_x, m1_y, m1_s, m1_sel, key);

  // Load with whitening, then advance one round per step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= req_type;
      if (req_type == xtea3_pkg::REQ_ENCIPHER) begin
        a   <= in_word0 + key[0];
        b   <= in_word1 + key[1];
        c   <= in_word2 + key[2];
        d   <= in_word3 + key[3];
        sum <= 32'd0;
      end else begin
        a   <= in_word0 ^ key[4];
        b   <= in_word1 ^ key[5];
        c   <= in_word2 ^ key[6];
        d   <= in_word3 ^ key[7];
        sum <= sum_init;
      end
    end else if (cmd.step) begin
      if (mode == xtea3_pkg::REQ_ENCIPHER) begin
        a   <= b;
        b   <= c + m1;
        c   <= d;
        d   <= a + m0;
        sum <= sum_inc;
      end else begin
        a   <= d - m0;
        b   <= a;
        c   <= b - m1;
        d   <= c;
        sum <= sum_dec;
      end
    end
  end

  // Apply the final key words into the output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (mode == xtea3_pkg::REQ_ENCIPHER) begin
        out_word0 <= a ^ key[4];
        out_word1 <= b ^ key[5];
        out_word2 <= c ^ key[6];
        out_word3 <= d ^ key[7];
      end else begin
        out_word0 <= a - key[0];
        out_word1 <= b - key[1];
        out_word2 <= c - key[2];
        out_word3 <= d - key[3];
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/xtea3_block_cipher_checker.sv =====
`timescale 1ns / 100ps

module xtea3_block_cipher_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [63:0] wr_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        req_type,
  input  wire logic [31:0] in_word0,
  input  wire logic [31:0] in_word1,
  input  wire logic [31:0] in_word2,
  input  wire logic [31:0] in_word3,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_word0,
  input  wire logic [31:0] out_word1,
  input  wire logic [31:0] out_word2,
  input  wire logic [31:0] out_word3,
  output int               errors,
  output int               pending,
  output int               checked
);

  // Word 0 sits at index 0
  typedef logic [0:3][31:0] block_words_t;

  logic [31:0]  key_word [8];
  logic [7:0]   round_total;
  block_words_t expected_blocks [$];

  // Rotate a key word left, amount taken modulo 32
  function automatic logic [31:0] rotate_key(input logic [31:0] v, input logic [31:0] amount);
    int unsigned s;
    s = amount % 32;
    if (s == 0)
      return v;
    return (v << s) | (v >> (32 - s));
  endfunction

  // Half-round mixing term
  function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [31:0] y,
                                            input logic [31:0] sum, input logic [1:0] sel);
    logic [31:0] p;
    logic [31:0] q;
    p = (x << 4) + rotate_key(key_word[int'(sel) + 4], x);
    q = (x >> 5) + rotate_key(key_word[sel], x >> 27);
    return p ^ (y + sum) ^ q;
  endfunction

  // Work out the block that the current key and round count give
  function automatic block_words_t transform_block(input logic op, input block_words_t blk);
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  c;
    logic [31:0]  d;
    logic [31:0]  t;
    logic [31:0]  sum;
    block_words_t res;
    if (op == xtea3_pkg::REQ_ENCIPHER) begin
      a = blk[0] + key_word[0];
      b = blk[1] + key_word[1];
      c = blk[2] + key_word[2];
      d = blk[3] + key_word[3];
      sum = '0;
      for (int i = 0; i < round_total; i++) begin
        a += round_mix(b, d, sum, sum[1:0]);
        sum += xtea3_pkg::DELTA;
        c += round_mix(d, b, sum, sum[12:11]);
        t = a; a = b; b = c; c = d; d = t;
      end
      res[0] = a ^ key_word[4];
      res[1] = b ^ key_word[5];
      res[2] = c ^ key_word[6];
      res[3] = d ^ key_word[7];
    end else begin
      a = blk[0] ^ key_word[4];
      b = blk[1] ^ key_word[5];
      c = blk[2] ^ key_word[6];
      d = blk[3] ^ key_word[7];
      sum = xtea3_pkg::DELTA * round_total;
      for (int i = 0; i < round_total; i++) begin
        t = d; d = c; c = b; b = a; a = t;
        c -= round_mix(d, b, sum, sum[12:11]);
        sum -= xtea3_pkg::DELTA;
        a -= round_mix(b, d, sum, sum[1:0]);
      end
      res[0] = a - key_word[0];
      res[1] = b - key_word[1];
      res[2] = c - key_word[2];
      res[3] = d - key_word[3];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    block_words_t got;
    block_words_t want;
    if (rst) begin
      foreach (key_word[i])
        key_word[i] = '0;
      round_total = xtea3_pkg::ROUNDS_RESET;
      expected_blocks.delete();
    end else begin
      // Mirror register writes; unknown indexes drop
      if (wr_en) begin
        case (wr_index)
          xtea3_pkg::REG_KEY01:  {key_word[1], key_word[0]} = wr_data;
          xtea3_pkg::REG_KEY23:  {key_word[3], key_word[2]} = wr_data;
          xtea3_pkg::REG_KEY45:  {key_word[5], key_word[4]} = wr_data;
          xtea3_pkg::REG_KEY67:  {key_word[7], key_word[6]} = wr_data;
          xtea3_pkg::REG_ROUNDS: round_total = wr_data[7:0];
          default: ;
        endcase
      end

      // Predict each accepted request
      if (in_valid && !in_stall)
        expected_blocks.push_back(transform_block(req_type,
                                                  {in_word0, in_word1, in_word2, in_word3}));

      // Compare each accepted result with the oldest prediction
      if (out_valid && !out_stall) begin
        got = {out_word0, out_word1, out_word2, out_word3};
        if (expected_blocks.size() == 0) begin
          $error("result %h with no request outstanding", got);
          errors++;
        end else begin
          want = expected_blocks.pop_front();
          checked++;
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              $error("out_word%0d expected %h got %h", i, want[i], got[i]);
              errors++;
            end
          end
        end
      end
    end
    pending = expected_blocks.size();
  end

endmodule

// ===== sim/xtea3_block_cipher_test.sv =====
`timescale 1ns / 100ps

module xtea3_block_cipher_test;

  localparam int RANDOM_BLOCKS = 500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [2:0] LAST_INDEX = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [2:0]  wr_index = '0;
  logic [63:0] wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = xtea3_pkg::REQ_ENCIPHER;
  logic [31:0] in_word0 = '0;
  logic [31:0] in_word1 = '0;
  logic [31:0] in_word2 = '0;
  logic [31:0] in_word3 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_word0;
  logic [31:0] out_word1;
  logic [31:0] out_word2;
  logic [31:0] out_word3;

  int errors;
  int pending;
  int checked;
  int cycle_count = 0;
  int sent_enc = 0;
  int sent_dec = 0;
  int settings_used = 0;
  int unsigned hold_cycles = 0;
  logic [0:3][31:0] last_result = '0;
  logic have_result = 1'b0;

  xtea3_block_cipher i_dut (.*);

  xtea3_block_cipher_checker i_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result side in random stretches, some long, some clear
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      hold_cycles <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
    end
  end

  // Keep the latest result to feed back as a later request
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_result <= {out_word0, out_word1, out_word2, out_word3};
      have_result <= 1'b1;
    end
  end

  task automatic send_block(input logic op, input logic [0:3][31:0] words);
    in_valid <= 1'b1;
    req_type <= op;
    in_word0 <= words[0];
    in_word1 <= words[1];
    in_word2 <= words[2];
    in_word3 <= words[3];
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (op == xtea3_pkg::REQ_ENCIPHER)
      sent_enc++;
    else
      sent_dec++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off requests until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
  endtask

  // Load a new key and round count once the block is idle
  task automatic configure(input logic [0:3][63:0] keys, input logic [7:0] rounds);
    drain();
    write_reg(xtea3_pkg::REG_KEY01, keys[0]);
    write_reg(xtea3_pkg::REG_KEY23, keys[1]);
    write_reg(xtea3_pkg::REG_KEY45, keys[2]);
    write_reg(xtea3_pkg::REG_KEY67, keys[3]);
    write_reg(xtea3_pkg::REG_ROUNDS, {$urandom, 24'($urandom), rounds});
    if ($urandom_range(0, 2) == 0)
      write_reg(3'($urandom_range(int'(LAST_INDEX), int'(xtea3_pkg::REG_ROUNDS) + 1)),
                {$urandom, $urandom});
    wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic int gap_length(input bit quiet);
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 60)
      return 0;
    if (p < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0]       rounds;
    logic [0:3][31:0] words;
    int               phase_items;
    bit               quiet;
    int               total;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero key, 32 rounds, both operations at the extremes
    send_block(xtea3_pkg::REQ_ENCIPHER, '0);
    send_block(xtea3_pkg::REQ_ENCIPHER, '1);
    send_block(xtea3_pkg::REQ_DECIPHER, '0);
    send_block(xtea3_pkg::REQ_DECIPHER, '1);
    pause(3);

    // Zero rounds: only the key words applied on load and on finish
    configure('1, 8'd0);
    send_block(xtea3_pkg::REQ_ENCIPHER, '0);
    send_block(xtea3_pkg::REQ_DECIPHER, '1);
    send_block(xtea3_pkg::REQ_ENCIPHER,
               {32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE});

    // Single round
    configure({rand_key(), rand_key(), rand_key(), rand_key()}, 8'd1);
    send_block(xtea3_pkg::REQ_ENCIPHER, {$urandom, $urandom, $urandom, $urandom});
    send_block(xtea3_pkg::REQ_DECIPHER, {$urandom, $urandom, $urandom, $urandom});

    // Largest round count
    configure('1, 8'd255);
    send_block(xtea3_pkg::REQ_ENCIPHER, '1);
    send_block(xtea3_pkg::REQ_DECIPHER, '0);

    // Split key halves, then decipher a fresh ciphertext back
    configure({64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
               64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 8'd32);
    send_block(xtea3_pkg::REQ_ENCIPHER, {$urandom, $urandom, $urandom, $urandom});
    drain();
    send_block(xtea3_pkg::REQ_DECIPHER, last_result);

    // Random phases, each with its own key and round count
    total = 0;
    while (total < RANDOM_BLOCKS) begin
      case ($urandom_range(0, 9))
        0: rounds = 8'd0;
        1: rounds = 8'd255;
        2: rounds = 8'($urandom_range(128, 254));
        default: rounds = 8'($urandom_range(1, 40));
      endcase
      configure({rand_key(), rand_key(), rand_key(), rand_key()}, rounds);
      phase_items = (rounds > 64) ? $urandom_range(3, 8) : $urandom_range(20, 50);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (phase_items) begin
        if ($urandom_range(0, 59) == 0)
          drain();
        if (have_result && $urandom_range(0, 3) == 0)
          words = last_result;
        else
          words = {rand_word(), rand_word(), rand_word(), rand_word()};
        send_block($urandom_range(0, 1) ? xtea3_pkg::REQ_DECIPHER
                                        : xtea3_pkg::REQ_ENCIPHER, words);
        pause(gap_length(quiet));
        total++;
      end
    end

    drain();
    repeat (300) @(posedge clk);
    $display("Sent %0d blocks (%0d encipher, %0d decipher) under %0d key and round settings,",
             sent_enc + sent_dec, sent_enc, sent_dec, settings_used);
    $display("round counts 0 to 255 with ciphertexts fed back; %0d results compared.", checked);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== xtea3_block_cipher.f =====
rtl/core/xtea3_pkg.sv
rtl/core/xtea3_ctrl.sv
rtl/core/xtea3_dp.sv
rtl/core/xtea3_block_cipher.sv
sim/xtea3_block_cipher_checker.sv
sim/xtea3_block_cipher_test.sv
